### sv/rectilinear_path_enclosed_area_macros.svh
// ============================================================================
// Assertion macros for the rectilinear path area counter
// Shorthand for clocked, reset-gated concurrent assertions.
// ============================================================================
`ifndef RECTILINEAR_PATH_ENCLOSED_AREA_MACROS_SVH
`define RECTILINEAR_PATH_ENCLOSED_AREA_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RPEA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RPEA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rpea_pkg.sv
// ============================================================================
// Rectilinear path area counter - shared package
// Field widths, payload structs, direction codes and defaults.
// ============================================================================
package rpea_pkg;

    localparam int STEP_FIELD_W    = 20;
    localparam int POS_W           = 32;
    localparam int ACC_W           = 64;
    localparam int PERIM_W         = 31;
    localparam int OUT_W           = 62;
    localparam int STEP_BITS_DEF   = 20;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_UP    = 2'd3
    } dir_t;

    // One move of the path
    typedef struct packed {
        logic [1:0]              direction;
        logic [STEP_FIELD_W-1:0] step_count;
        logic                    last_move;
    } move_t;

    // One area result
    typedef struct packed {
        logic [OUT_W-1:0] enclosed_cells;
        logic             overflow;
    } area_t;

    // Classification of a move, handed from front to back
    typedef struct packed {
        logic neg;   // subtract the cross term
        logic last;  // closes the path
    } cls_t;

endpackage

### sv/rectilinear_path_enclosed_area.sv
// ============================================================================
// Rectilinear path enclosed area counter - top level
// Counts the lattice cells enclosed by a closed rectilinear path, boundary
// included, one move per beat.
// ============================================================================
//
//  Channel | Direction | Handshake                 | Beat
//  --------+-----------+---------------------------+---------------------------
//  move    | in        | move_valid / move_ready   | direction, step, last flag
//  area    | out       | area_valid / area_ready   | cell count, overflow flag
//
//  One move is taken every cycle while the command queue has room.
//  area_valid rises once the closing move has passed queue write, queue read
//  and multiply, accumulate, magnitude and output register, in that order.
//  The queue (QUEUE_DEPTH beats) lets the front keep taking moves while
//  a result waits on area_ready; the back stalls only its closing-move path.
//  Reset clears the vertex, accumulators and all valid flags at once.
//
`include "rectilinear_path_enclosed_area_macros.svh"

module rectilinear_path_enclosed_area #(
    parameter int STEP_BITS   = rpea_pkg::STEP_BITS_DEF,
    parameter int QUEUE_DEPTH = rpea_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            move_valid,
    output logic            move_ready,
    input  rpea_pkg::move_t move,
    output logic            area_valid,
    input  logic            area_ready,
    output rpea_pkg::area_t area
);
    import rpea_pkg::*;

    localparam int CLS_W = $bits(cls_t);
    localparam int Q_W   = STEP_BITS + POS_W + CLS_W;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                    q_push, q_pop, q_full, q_empty;
    logic [CNT_W-1:0]        q_count;
    logic [Q_W-1:0]          q_push_data, q_pop_data;

    logic [STEP_BITS-1:0]    f_step, b_step;
    logic signed [POS_W-1:0] f_coord, b_coord;
    cls_t                    f_cls, b_cls;

    rpea_front #(
        .STEP_BITS (STEP_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .move_valid (move_valid),
        .move_ready (move_ready),
        .move       (move),
        .q_full     (q_full),
        .q_push     (q_push),
        .step       (f_step),
        .coord      (f_coord),
        .cls        (f_cls)
    );

    // Pack and unpack the queued command
    assign q_push_data = {f_cls, f_coord, f_step};
    assign b_step      = q_pop_data[STEP_BITS-1:0];
    assign b_coord     = $signed(q_pop_data[STEP_BITS +: POS_W]);
    assign b_cls       = cls_t'(q_pop_data[STEP_BITS + POS_W +: CLS_W]);

    rpea_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .full      (q_full),
        .empty     (q_empty),
        .count     (q_count)
    );

    rpea_back #(
        .STEP_BITS (STEP_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .step       (b_step),
        .coord      (b_coord),
        .cls        (b_cls),
        .area_valid (area_valid),
        .area_ready (area_ready),
        .area       (area)
    );

    // A taken move sits in the queue on the following cycle
    `RPEA_ASSERT_NEXT(a_push_lands, clk, rst_n, move_valid && move_ready,
        q_count != '0, "taken move not queued")
    // Simultaneous push and pop leave the fill level alone
    `RPEA_ASSERT_NEXT(a_count_steady, clk, rst_n, q_push && q_pop,
        $stable(q_count), "queue count drift")
    // An overflowing result carries the saturated count
    `RPEA_ASSERT_NOW(a_sat_value, clk, rst_n, area_valid && area.overflow,
        &area.enclosed_cells, "overflow without saturation")

endmodule

### sv/rpea_queue.sv
// ============================================================================
// Rectilinear path area counter - command queue
// Small first-in first-out buffer between the front and the back.
// ============================================================================
module rpea_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rpea_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import rpea_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Advance pointers with wrap at the depth and update the fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem[rd_ptr_reg];
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

endmodule

### sv/rpea_front.sv
// ============================================================================
// Rectilinear path area counter - front end
// Accepts moves, tracks the current vertex and classifies each move into
// the coordinate, sign and step that the back end multiplies.
// ============================================================================
module rpea_front #(
    parameter int STEP_BITS = rpea_pkg::STEP_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          move_valid,
    output logic                          move_ready,
    input  rpea_pkg::move_t               move,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [STEP_BITS-1:0]          step,
    output logic signed [rpea_pkg::POS_W-1:0] coord,
    output rpea_pkg::cls_t                cls
);
    import rpea_pkg::*;

    logic [STEP_BITS-1:0] s;
    logic [POS_W-1:0]     s_ext;
    logic [POS_W-1:0]     pos_x_reg, pos_x_next;
    logic [POS_W-1:0]     pos_y_reg, pos_y_next;

    // Take the step at the configured width
    if (STEP_BITS <= STEP_FIELD_W)
    begin : g_step_trunc
        assign s = move.step_count[STEP_BITS-1:0];
    end
    else
    begin : g_step_ext
        assign s = {{(STEP_BITS - STEP_FIELD_W){1'b0}}, move.step_count};
    end

    assign s_ext      = {{(POS_W - STEP_BITS){1'b0}}, s};
    assign move_ready = !q_full;
    assign q_push     = move_valid && !q_full;
    assign step       = s;

    // Decode direction: pick the cross coordinate, its sign and the new vertex
    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        unique case (dir_t'(move.direction))
            DIR_RIGHT:
            begin
                coord      = $signed(pos_y_reg);
                cls.neg    = 1'b1;
                pos_x_next = pos_x_reg + s_ext;
            end
            DIR_DOWN:
            begin
                coord      = $signed(pos_x_reg);
                cls.neg    = 1'b0;
                pos_y_next = pos_y_reg + s_ext;
            end
            DIR_LEFT:
            begin
                coord      = $signed(pos_y_reg);
                cls.neg    = 1'b0;
                pos_x_next = pos_x_reg - s_ext;
            end
            DIR_UP:
            begin
                coord      = $signed(pos_x_reg);
                cls.neg    = 1'b1;
                pos_y_next = pos_y_reg - s_ext;
            end
        endcase
        cls.last = move.last_move;
        // Closing move returns the walk to the origin
        if (move.last_move)
        begin
            pos_x_next = '0;
            pos_y_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end
        else if (q_push)
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

endmodule

### sv/rpea_back.sv
// ============================================================================
// Rectilinear path area counter - back end
// Multiplies each classified move, accumulates twice the area and the
// perimeter, and on the closing move forms the cell count by Pick's rule.
// ============================================================================
module rpea_back #(
    parameter int STEP_BITS = rpea_pkg::STEP_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    output logic                              q_pop,
    input  logic [STEP_BITS-1:0]              step,
    input  logic signed [rpea_pkg::POS_W-1:0] coord,
    input  rpea_pkg::cls_t                    cls,
    output logic                              area_valid,
    input  logic                              area_ready,
    output rpea_pkg::area_t                   area
);
    import rpea_pkg::*;

    localparam int PROD_W = STEP_BITS + 1 + POS_W;

    // Product stage
    logic                     p_vld_reg;
    logic signed [PROD_W-1:0] p_prod_reg;
    logic [STEP_BITS-1:0]     p_step_reg;
    cls_t                     p_cls_reg;
    logic signed [PROD_W-1:0] prod_c;

    // Accumulators
    logic [ACC_W-1:0]   acc_reg;
    logic [PERIM_W-1:0] perim_reg;
    logic [ACC_W-1:0]   term_c;
    logic [ACC_W-1:0]   acc_next;
    logic [PERIM_W:0]   perim_sum;
    logic [PERIM_W-1:0] perim_next;

    // Final accumulator stage
    logic               c_vld_reg;
    logic [ACC_W-1:0]   c_acc_reg;
    logic [PERIM_W-1:0] c_perim_reg;

    // Magnitude stage
    logic               m_vld_reg;
    logic [ACC_W-1:0]   m_mag_reg;
    logic [PERIM_W-1:0] m_perim_reg;
    logic [ACC_W-1:0]   mag_c;

    // Output register
    logic               area_valid_reg;
    area_t              area_reg;
    logic [ACC_W-1:0]   total_c;
    logic               ovf_c;

    logic d_free, m_free, c_free, p_move, p_free;

    // Stage handshakes, back to front
    assign d_free = !area_valid_reg || area_ready;
    assign m_free = !m_vld_reg || d_free;
    assign c_free = !c_vld_reg || m_free;
    assign p_move = p_vld_reg && (!p_cls_reg.last || c_free);
    assign p_free = !p_vld_reg || p_move;
    assign q_pop  = !q_empty && p_free;

    // Cross term step * coordinate
    assign prod_c = $signed({1'b0, step}) * coord;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
            p_cls_reg <= '0;
        end
        else if (p_free)
        begin
            p_vld_reg <= q_pop;
            p_cls_reg <= cls;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            p_prod_reg <= prod_c;
            p_step_reg <= step;
        end
    end

    // Accumulate signed area and saturating perimeter
    always_comb
    begin
        term_c     = {{(ACC_W - PROD_W){p_prod_reg[PROD_W-1]}}, p_prod_reg};
        acc_next   = p_cls_reg.neg ? (acc_reg - term_c) : (acc_reg + term_c);
        perim_sum  = {1'b0, perim_reg} + (PERIM_W + 1)'(p_step_reg);
        perim_next = perim_sum[PERIM_W] ? '1 : perim_sum[PERIM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            perim_reg <= '0;
        end
        else if (p_move)
        begin
            if (p_cls_reg.last)
            begin
                acc_reg   <= '0;
                perim_reg <= '0;
            end
            else
            begin
                acc_reg   <= acc_next;
                perim_reg <= perim_next;
            end
        end
    end

    // Capture the totals of a closed path
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else if (c_free)
        begin
            c_vld_reg <= p_move && p_cls_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_move && p_cls_reg.last && c_free)
        begin
            c_acc_reg   <= acc_next;
            c_perim_reg <= perim_next;
        end
    end

    // Take the magnitude of the accumulator
    assign mag_c = c_acc_reg[ACC_W-1] ? (~c_acc_reg + ACC_W'(1)) : c_acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else if (m_free)
        begin
            m_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_vld_reg && m_free)
        begin
            m_mag_reg   <= mag_c;
            m_perim_reg <= c_perim_reg;
        end
    end

    // Area (half the shoelace sum) plus half perimeter plus one, saturated
    assign total_c = {1'b0, m_mag_reg[ACC_W-1:1]}
                   + ACC_W'(m_perim_reg[PERIM_W-1:1])
                   + ACC_W'(1);
    assign ovf_c   = |total_c[ACC_W-1:OUT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_valid_reg <= 1'b0;
        end
        else if (d_free)
        begin
            area_valid_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_vld_reg && d_free)
        begin
            area_reg.enclosed_cells <= ovf_c ? '1 : total_c[OUT_W-1:0];
            area_reg.overflow       <= ovf_c;
        end
    end

    assign area_valid = area_valid_reg;
    assign area       = area_reg;

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// Rectilinear path area counter - testbench
// Streams closed and open lattice paths and short hand-built shapes into
// the block.
// A shadow of the vertex, shoelace and perimeter registers predicts each
// area beat. Both channels idle and stall at random.
// ============================================================================
module testbench;
    import rpea_pkg::*;

    localparam int          STEP_BITS    = STEP_BITS_DEF;
    localparam int          SUM_W        = ACC_W + 1;
    localparam int          RANDOM_MOVES = 1500;
    localparam int          MAX_GAP      = 11;
    localparam int          DRAIN_CYCLES = 20;
    localparam longint      CYCLE_LIMIT  = 1000000;

    localparam logic [STEP_FIELD_W-1:0] STEP_MAX  = '1;
    localparam logic [PERIM_W-1:0]      PERIM_SAT = '1;
    localparam logic [OUT_W-1:0]        CELLS_SAT = '1;

    logic  clk;
    logic  rst_n;
    logic  move_valid;
    logic  move_ready;
    move_t move;
    logic  area_valid;
    logic  area_ready;
    area_t area;

    rectilinear_path_enclosed_area u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .move_valid (move_valid),
        .move_ready (move_ready),
        .move       (move),
        .area_valid (area_valid),
        .area_ready (area_ready),
        .area       (area)
    );

    // Shadow of the block's path registers
    logic [POS_W-1:0]   vertex_x   = '0;
    logic [POS_W-1:0]   vertex_y   = '0;
    logic [ACC_W-1:0]   twice_area = '0;
    logic [PERIM_W-1:0] perimeter  = '0;

    move_t  pending_moves[$];
    area_t  expected_areas[$];

    int     moves_total    = 0;
    int     moves_accepted = 0;
    int     error_count    = 0;
    bit     move_beat      = 1'b0;
    bit     area_beat      = 1'b0;
    int     move_gap       = 0;
    int     move_burst     = 0;
    int     ready_hold     = 0;
    int     ready_burst    = 0;
    longint cycle_count    = 0;

    // Stimulus-side position, used only to close random paths
    longint track_x = 0;
    longint track_y = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Apply one move to the shadow state; return 1 with the area on a closing move
    function automatic bit trace_move(input move_t mv, output area_t res);
        logic [ACC_W-1:0] span;
        logic [ACC_W-1:0] x_ext;
        logic [ACC_W-1:0] y_ext;
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] perim_next;
        logic [SUM_W-1:0] total;
        span  = ACC_W'(mv.step_count) & ((ACC_W'(1) << STEP_BITS) - 1);
        x_ext = {{(ACC_W-POS_W){vertex_x[POS_W-1]}}, vertex_x};
        y_ext = {{(ACC_W-POS_W){vertex_y[POS_W-1]}}, vertex_y};
        res   = '0;
        case (dir_t'(mv.direction))
            DIR_RIGHT:
            begin
                twice_area = twice_area - span * y_ext;
                vertex_x   = vertex_x + span[POS_W-1:0];
            end
            DIR_DOWN:
            begin
                twice_area = twice_area + span * x_ext;
                vertex_y   = vertex_y + span[POS_W-1:0];
            end
            DIR_LEFT:
            begin
                twice_area = twice_area + span * y_ext;
                vertex_x   = vertex_x - span[POS_W-1:0];
            end
            DIR_UP:
            begin
                twice_area = twice_area - span * x_ext;
                vertex_y   = vertex_y - span[POS_W-1:0];
            end
        endcase
        // Saturate the perimeter rather than wrap it
        perim_next = ACC_W'(perimeter) + span;
        perimeter  = (perim_next > ACC_W'(PERIM_SAT)) ? PERIM_SAT : perim_next[PERIM_W-1:0];
        if (!mv.last_move)
            return 1'b0;
        // Pick's theorem on the magnitude of the shoelace sum
        mag   = twice_area[ACC_W-1] ? -twice_area : twice_area;
        total = SUM_W'(mag >> 1) + SUM_W'(perimeter >> 1) + SUM_W'(1);
        if (total > SUM_W'(CELLS_SAT))
        begin
            res.enclosed_cells = CELLS_SAT;
            res.overflow       = 1'b1;
        end
        else
        begin
            res.enclosed_cells = total[OUT_W-1:0];
            res.overflow       = 1'b0;
        end
        vertex_x   = '0;
        vertex_y   = '0;
        twice_area = '0;
        perimeter  = '0;
        return 1'b1;
    endfunction

    // Draw the wait before the next beat; hold runs of zero waits now and then
    function automatic int draw_wait(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            burst = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at %0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic push_move(input dir_t dir, input logic [STEP_FIELD_W-1:0] step,
                             input bit closing);
        move_t mv;
        mv.direction  = dir;
        mv.step_count = step;
        mv.last_move  = closing;
        pending_moves = {pending_moves, mv};
        case (dir)
            DIR_RIGHT: track_x += longint'(step);
            DIR_DOWN:  track_y += longint'(step);
            DIR_LEFT:  track_x -= longint'(step);
            DIR_UP:    track_y -= longint'(step);
        endcase
    endtask

    // Mostly short steps, some medium, a few across the whole field
    function automatic logic [STEP_FIELD_W-1:0] draw_step();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return STEP_FIELD_W'($urandom_range(0, 15));
        else if (pick < 9)
            return STEP_FIELD_W'($urandom_range(0, 4095));
        return STEP_FIELD_W'($urandom);
    endfunction

    // Random walk, optionally walked back to the origin, ended by a closing beat
    task automatic add_random_path(input bit closed);
        int                      count;
        longint                  span;
        logic [STEP_FIELD_W-1:0] step;
        move_t                   tail;
        track_x = 0;
        track_y = 0;
        count   = $urandom_range(1, 24);
        repeat (count)
            push_move(dir_t'($urandom_range(0, 3)), draw_step(), 1'b0);
        if (closed)
        begin
            while (track_x != 0)
            begin
                span = (track_x > 0) ? track_x : -track_x;
                step = (span > longint'(STEP_MAX)) ? STEP_MAX : STEP_FIELD_W'(span);
                push_move((track_x > 0) ? DIR_LEFT : DIR_RIGHT, step, 1'b0);
            end
            while (track_y != 0)
            begin
                span = (track_y > 0) ? track_y : -track_y;
                step = (span > longint'(STEP_MAX)) ? STEP_MAX : STEP_FIELD_W'(span);
                push_move((track_y > 0) ? DIR_UP : DIR_DOWN, step, 1'b0);
            end
        end
        tail = pending_moves.pop_back();
        tail.last_move = 1'b1;
        pending_moves = {pending_moves, tail};
    endtask

    // Observe both channels: predict on move beats, check area beats
    always @(posedge clk)
    begin : observe
        area_t want;
        move_beat = rst_n && move_valid && move_ready;
        area_beat = rst_n && area_valid && area_ready;
        if (move_beat)
        begin
            moves_accepted++;
            if (trace_move(move, want))
                expected_areas = {expected_areas, want};
        end
        if (area_beat)
        begin
            if (expected_areas.size() == 0)
                report_mismatch("area beat with no closing move pending",
                                64'(area.enclosed_cells), 64'(0));
            else
            begin
                want = expected_areas.pop_front();
                if (area.enclosed_cells !== want.enclosed_cells)
                    report_mismatch("enclosed_cells", 64'(area.enclosed_cells),
                                    64'(want.enclosed_cells));
                if (area.overflow !== want.overflow)
                    report_mismatch("overflow", 64'(area.overflow), 64'(want.overflow));
            end
        end
    end

    // Move driver: hold the beat until taken, then idle or present the next one
    always @(negedge clk)
    begin
        if (rst_n && !(move_valid && !move_beat))
        begin
            if (move_gap > 0)
            begin
                move_gap--;
                move_valid <= 1'b0;
            end
            else if (pending_moves.size() > 0)
            begin
                move       <= pending_moves.pop_front();
                move_valid <= 1'b1;
                move_gap    = draw_wait(move_burst);
            end
            else
                move_valid <= 1'b0;
        end
    end

    // Area receiver: draw a possibly empty stall after each beat, and drop ready now and then between
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (area_beat || (ready_hold == 0 && $urandom_range(0, 15) == 0))
                ready_hold = draw_wait(ready_burst);
            if (ready_hold > 0)
            begin
                ready_hold--;
                area_ready <= 1'b0;
            end
            else
                area_ready <= 1'b1;
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("rectilinear_path_enclosed_area test failed");
        $finish;
    end

    // Build the stimulus, run it through and wait for the pipeline to drain
    initial
    begin
        int closed_pick;
        rst_n      = 1'b0;
        move_valid = 1'b0;
        move       = '0;
        area_ready = 1'b0;

        // Zero-length path made of one closing beat
        push_move(DIR_RIGHT, '0, 1'b1);
        // Unit square, clockwise
        push_move(DIR_RIGHT, STEP_FIELD_W'(1), 1'b0);
        push_move(DIR_DOWN, STEP_FIELD_W'(1), 1'b0);
        push_move(DIR_LEFT, STEP_FIELD_W'(1), 1'b0);
        push_move(DIR_UP, STEP_FIELD_W'(1), 1'b1);
        // Anticlockwise rectangle: negative shoelace sum
        push_move(DIR_DOWN, STEP_FIELD_W'(2), 1'b0);
        push_move(DIR_RIGHT, STEP_FIELD_W'(3), 1'b0);
        push_move(DIR_UP, STEP_FIELD_W'(2), 1'b0);
        push_move(DIR_LEFT, STEP_FIELD_W'(3), 1'b1);
        // Square of full-length sides
        push_move(DIR_RIGHT, STEP_MAX, 1'b0);
        push_move(DIR_DOWN, STEP_MAX, 1'b0);
        push_move(DIR_LEFT, STEP_MAX, 1'b0);
        push_move(DIR_UP, STEP_MAX, 1'b1);
        // Open path with an odd perimeter
        push_move(DIR_RIGHT, STEP_FIELD_W'(3), 1'b0);
        push_move(DIR_DOWN, STEP_FIELD_W'(2), 1'b1);
        // Zero-length moves inside a closed path
        push_move(DIR_RIGHT, STEP_FIELD_W'(2), 1'b0);
        push_move(DIR_DOWN, '0, 1'b0);
        push_move(DIR_DOWN, STEP_FIELD_W'(2), 1'b0);
        push_move(DIR_LEFT, STEP_FIELD_W'(2), 1'b0);
        push_move(DIR_UP, '0, 1'b0);
        push_move(DIR_UP, STEP_FIELD_W'(2), 1'b1);

        // Random paths: mostly closed, the rest left open
        moves_total = pending_moves.size();
        while (pending_moves.size() - moves_total < RANDOM_MOVES)
        begin
            closed_pick = $urandom_range(0, 4);
            add_random_path(closed_pick != 0);
        end
        moves_total = pending_moves.size();

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        while (moves_accepted < moves_total)
            @(posedge clk);
        while (expected_areas.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("rectilinear_path_enclosed_area test passed");
        else
            $display("rectilinear_path_enclosed_area test failed");
        $finish;
    end

endmodule

### rectilinear_path_enclosed_area.f
+incdir+sv
sv/rpea_pkg.sv
sv/rpea_queue.sv
sv/rpea_front.sv
sv/rpea_back.sv
sv/rectilinear_path_enclosed_area.sv
sim/testbench.sv
